// File: hdl/segment_box_face_hit_macros.svh
// Assertion macros used by the top RTL file of the segment box face hit block.
`ifndef SEGMENT_BOX_FACE_HIT_MACROS_SVH
`define SEGMENT_BOX_FACE_HIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SBFH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SBFH_ASSERT_NEVER(lbl, clk, rst, bad, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(bad)) else $error(msg);
`else
`define SBFH_ASSERT(lbl, clk, rst, prop, msg)
`define SBFH_ASSERT_NEVER(lbl, clk, rst, bad, msg)
`endif
`endif

// File: hdl/sbfh_pkg.sv
package sbfh_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_LANES  = 2 * NUM_AXES;
  localparam int QUOT_BITS  = 34;
  localparam int PROJ_LAT   = QUOT_BITS + 2;
  localparam int TOTAL_LAT  = PROJ_LAT + 4;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } query_t;

  typedef struct packed {
    logic   crossed;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } result_t;

  typedef struct packed {
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] mag_c;
    logic        neg;
  } lane_op_t;

  typedef struct packed {
    logic [QUOT_BITS-1:0] quot;
    logic                 ovf;
    logic                 neg;
  } lane_res_t;

  typedef struct packed {
    logic         reject;
    logic [2:0]   dir_zero;
    coord_t [2:0] face;
    coord_t [2:0] start;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } side_t;

endpackage

// File: hdl/sbfh_front.sv
module sbfh_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    mode,
  input  sbfh_pkg::query_t                        query,
  output logic                                    out_valid,
  output sbfh_pkg::lane_op_t [sbfh_pkg::NUM_LANES-1:0] ops,
  output sbfh_pkg::side_t                         side
);
  import sbfh_pkg::*;

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  coord_t [2:0]        s;
  coord_t [2:0]        e;
  coord_t [2:0]        lo;
  coord_t [2:0]        hi;
  logic   [2:0][32:0]  d;
  logic   [2:0][32:0]  off;
  logic   [2:0]        dz;
  coord_t [2:0]        face;
  logic                outside;
  lane_op_t [NUM_LANES-1:0] ops_next;
  side_t               side_next;

  always_comb begin
    int o;
    s  = {query.start_z, query.start_y, query.start_x};
    e  = {query.end_z, query.end_y, query.end_x};
    lo = {query.box_min_z, query.box_min_y, query.box_min_x};
    hi = {query.box_max_z, query.box_max_y, query.box_max_x};
    outside = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      d[i]    = {e[i][31], e[i]} - {s[i][31], s[i]};
      dz[i]   = (d[i] == '0);
      face[i] = (mode ? (!d[i][32] && !dz[i]) : d[i][32]) ? hi[i] : lo[i];
      off[i]  = {face[i][31], face[i]} - {s[i][31], s[i]};
      if (e[i] < lo[i] || e[i] > hi[i]) begin
        outside = 1'b1;
      end
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int k = 0; k < 2; k++) begin
        o = ax + 1 + k;
        if (o >= NUM_AXES) begin
          o = o - NUM_AXES;
        end
        ops_next[2*ax+k].mag_a = mag33(off[ax]);
        ops_next[2*ax+k].mag_b = mag33(d[o]);
        ops_next[2*ax+k].mag_c = mag33(d[ax]);
        ops_next[2*ax+k].neg   = off[ax][32] ^ d[o][32] ^ d[ax][32];
      end
    end
    side_next.reject   = !mode && outside;
    side_next.dir_zero = dz;
    side_next.face     = face;
    side_next.start    = s;
    side_next.lo       = lo;
    side_next.hi       = hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    ops  <= ops_next;
    side <= side_next;
  end

endmodule

// File: hdl/sbfh_lane.sv
module sbfh_lane (
  input  logic                clk,
  input  sbfh_pkg::lane_op_t  op,
  output sbfh_pkg::lane_res_t res
);
  import sbfh_pkg::*;

  logic [63:0] prod;
  logic [31:0] c1;
  logic        neg1;

  logic [31:0]          rem  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] sh   [QUOT_BITS+1];
  logic [31:0]          cst  [QUOT_BITS+1];
  logic                 ngst [QUOT_BITS+1];
  logic                 ovst [QUOT_BITS+1];

  always_ff @(posedge clk) begin
    prod <= op.mag_a * op.mag_b;
    c1   <= op.mag_c;
    neg1 <= op.neg;
  end

  always_ff @(posedge clk) begin
    rem[0]  <= {2'b00, prod[63:QUOT_BITS]};
    sh[0]   <= prod[QUOT_BITS-1:0];
    cst[0]  <= c1;
    ngst[0] <= neg1;
    ovst[0] <= ({2'b00, prod[63:QUOT_BITS]} >= c1);
  end

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
    logic [32:0] trial;
    logic [33:0] diff;
    assign trial = {rem[i], sh[i][QUOT_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, cst[i]};
    always_ff @(posedge clk) begin
      rem[i+1]  <= diff[33] ? trial[31:0] : diff[31:0];
      sh[i+1]   <= {sh[i][QUOT_BITS-2:0], !diff[33]};
      cst[i+1]  <= cst[i];
      ngst[i+1] <= ngst[i];
      ovst[i+1] <= ovst[i];
    end
  end

  assign res.quot = sh[QUOT_BITS];
  assign res.ovf  = ovst[QUOT_BITS];
  assign res.neg  = ngst[QUOT_BITS];

endmodule

// File: hdl/sbfh_back.sv
module sbfh_back (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  input  sbfh_pkg::side_t                           side,
  input  sbfh_pkg::lane_res_t [sbfh_pkg::NUM_LANES-1:0] lres,
  output logic                                      done,
  output sbfh_pkg::result_t                         result
);
  import sbfh_pkg::*;

  coord_t [NUM_LANES-1:0] proj_next;
  coord_t [NUM_LANES-1:0] proj;
  side_t                  side_a;
  logic                   valid_a;
  logic   [2:0]           inb;
  result_t                result_next;

  always_comb begin
    int o;
    logic [QUOT_BITS:0] mag;
    logic [35:0]        sq;
    logic [35:0]        sum;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int k = 0; k < 2; k++) begin
        o = ax + 1 + k;
        if (o >= NUM_AXES) begin
          o = o - NUM_AXES;
        end
        mag = lres[2*ax+k].ovf ? {1'b1, {QUOT_BITS{1'b0}}} : {1'b0, lres[2*ax+k].quot};
        sq  = {{(35-QUOT_BITS){1'b0}}, mag};
        if (lres[2*ax+k].neg) begin
          sq = -sq;
        end
        sum = {{4{side.start[o][31]}}, side.start[o]} + sq;
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
          proj_next[2*ax+k] = sum[31:0];
        end else if (sum[35]) begin
          proj_next[2*ax+k] = 32'sh8000_0000;
        end else begin
          proj_next[2*ax+k] = 32'sh7fff_ffff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else begin
      valid_a <= in_valid;
    end
    proj   <= proj_next;
    side_a <= side;
  end

  always_comb begin
    int o1;
    int o2;
    coord_t [2:0] pt;
    logic hit;
    logic stop;
    pt   = '0;
    hit  = 1'b0;
    stop = side_a.reject;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      o1 = (ax + 1 >= NUM_AXES) ? ax + 1 - NUM_AXES : ax + 1;
      o2 = (ax + 2 >= NUM_AXES) ? ax + 2 - NUM_AXES : ax + 2;
      inb[ax] = proj[2*ax] >= side_a.lo[o1] && proj[2*ax] <= side_a.hi[o1] &&
                proj[2*ax+1] >= side_a.lo[o2] && proj[2*ax+1] <= side_a.hi[o2];
      if (!stop) begin
        if (side_a.dir_zero[ax]) begin
          if (ax == NUM_AXES - 1) begin
            hit  = 1'b1;
            stop = 1'b1;
          end
        end else begin
          pt[ax] = side_a.face[ax];
          pt[o1] = proj[2*ax];
          pt[o2] = proj[2*ax+1];
          if (inb[ax]) begin
            hit  = 1'b1;
            stop = 1'b1;
          end
        end
      end
    end
    result_next.crossed = hit;
    result_next.point_x = pt[0];
    result_next.point_y = pt[1];
    result_next.point_z = pt[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_a;
    end
    result <= result_next;
  end

endmodule

// File: hdl/segment_box_face_hit.sv
// Channel   Direction  Handshake                Payload
// query     in         start high, busy low     query_t: segment ends and box corners
// result    out        done strobe, one cycle   result_t: crossed flag and point
// config    in         cfg_valid and cfg_ready  cfg_data: entry mode bit
//
// One query enters every cycle; busy is always low.
// A result appears after its query passes the input register, the front stage,
// six restoring dividers (one quotient bit per stage over 34 stages) and sbfh_back.
// Reset is synchronous and clears all valid bits and the entry mode.
// The receiver cannot stall, so the pipeline never holds.
`include "segment_box_face_hit_macros.svh"

module segment_box_face_hit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sbfh_pkg::query_t  query,
  output logic              done,
  output sbfh_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import sbfh_pkg::*;

  logic                     mode;
  logic                     v_in;
  logic                     mode_in;
  query_t                   q_in;
  logic                     v_front;
  lane_op_t [NUM_LANES-1:0] ops;
  side_t                    side_front;
  lane_res_t [NUM_LANES-1:0] lres;
  side_t                    side_d  [PROJ_LAT];
  logic                     valid_d [PROJ_LAT];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      v_in <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      v_in <= start && !busy;
    end
    q_in    <= query;
    mode_in <= mode;
  end

  sbfh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_in),
    .mode      (mode_in),
    .query     (q_in),
    .out_valid (v_front),
    .ops       (ops),
    .side      (side_front)
  );

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    sbfh_lane u_lane (
      .clk (clk),
      .op  (ops[j]),
      .res (lres[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROJ_LAT; i++) begin
        valid_d[i] <= 1'b0;
      end
    end else begin
      valid_d[0] <= v_front;
      for (int i = 1; i < PROJ_LAT; i++) begin
        valid_d[i] <= valid_d[i-1];
      end
    end
    side_d[0] <= side_front;
    for (int i = 1; i < PROJ_LAT; i++) begin
      side_d[i] <= side_d[i-1];
    end
  end

  sbfh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (valid_d[PROJ_LAT-1]),
    .side     (side_d[PROJ_LAT-1]),
    .lres     (lres),
    .done     (done),
    .result   (result)
  );

  `SBFH_ASSERT(a_latency, clk, rst, (start && !busy) |-> ##TOTAL_LAT done, "result missing")
  `SBFH_ASSERT(a_no_extra, clk, rst, done |-> $past(start && !busy, TOTAL_LAT), "stray result")
  `SBFH_ASSERT(a_cfg, clk, rst, cfg_valid && cfg_ready |=> mode == $past(cfg_data), "lost write")

endmodule

// File: test/segment_box_face_hit_tb.sv
module segment_box_face_hit_tb;
  import sbfh_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = TOTAL_LAT + 20;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  query_t query;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  segment_box_face_hit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .query(query),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  query_t pending_queries[$];
  result_t expected_hits[$];
  logic mode_model;
  int mismatch_count;
  int sent_count;
  int checked_count;
  int hit_count;
  int quiet_cycles;
  logic idle_enable;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] project_coord(input logic signed [63:0] base,
      input logic signed [63:0] off, input logic signed [63:0] d_o,
      input logic signed [63:0] d_a);
    logic neg;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] q;
    logic signed [63:0] qs;
    neg = (off < 0) ^ (d_o < 0) ^ (d_a < 0);
    a = (off < 0) ? -off : off;
    b = (d_o < 0) ? -d_o : d_o;
    c = (d_a < 0) ? -d_a : d_a;
    q = (a * b) / c;
    if (q > (64'd1 << 34)) q = 64'd1 << 34;
    qs = neg ? -$signed(q) : $signed(q);
    return clamp32(base + qs);
  endfunction

  function automatic result_t predict_hit(input query_t q, input logic mode);
    logic signed [63:0] s[3];
    logic signed [63:0] e[3];
    logic signed [63:0] lo[3];
    logic signed [63:0] hi[3];
    logic signed [63:0] d[3];
    logic signed [63:0] p[3];
    logic signed [63:0] face;
    logic fin;
    logic hit;
    logic use_max;
    int o1;
    int o2;
    result_t r;
    s[0] = q.start_x; s[1] = q.start_y; s[2] = q.start_z;
    e[0] = q.end_x; e[1] = q.end_y; e[2] = q.end_z;
    lo[0] = q.box_min_x; lo[1] = q.box_min_y; lo[2] = q.box_min_z;
    hi[0] = q.box_max_x; hi[1] = q.box_max_y; hi[2] = q.box_max_z;
    fin = 1'b0;
    hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d[k] = e[k] - s[k];
      p[k] = 0;
      if (!mode && (e[k] < lo[k] || e[k] > hi[k])) fin = 1'b1;
    end
    for (int ax = 0; ax < 3; ax++) begin
      if (!fin) begin
        o1 = (ax + 1) % 3;
        o2 = (ax + 2) % 3;
        if (d[ax] == 0) begin
          if (ax == 2) begin
            hit = 1'b1;
            fin = 1'b1;
          end
        end else begin
          use_max = mode ? (d[ax] > 0) : (d[ax] < 0);
          face = use_max ? hi[ax] : lo[ax];
          p[ax] = face;
          p[o1] = project_coord(s[o1], face - s[ax], d[o1], d[ax]);
          p[o2] = project_coord(s[o2], face - s[ax], d[o2], d[ax]);
          if (p[o1] >= lo[o1] && p[o1] <= hi[o1] && p[o2] >= lo[o2] && p[o2] <= hi[o2]) begin
            hit = 1'b1;
            fin = 1'b1;
          end
        end
      end
    end
    r.crossed = hit;
    r.point_x = p[0][31:0];
    r.point_y = p[1][31:0];
    r.point_z = p[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch %0s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_hits.push_back(predict_hit(query, mode_model));
        sent_count++;
      end
      if (start && busy) begin
      end else if (pending_queries.size() > 0 && (!idle_enable || $urandom_range(99) >= 20))
          begin
        start <= 1'b1;
        query <= pending_queries.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(result.crossed), 32'd0);
      end else begin
        result_t want;
        want = expected_hits.pop_front();
        checked_count++;
        if (want.crossed) hit_count++;
        if (result.crossed !== want.crossed)
          report_mismatch("crossed", 32'(result.crossed), 32'(want.crossed));
        if (result.point_x !== want.point_x)
          report_mismatch("point_x", result.point_x, want.point_x);
        if (result.point_y !== want.point_y)
          report_mismatch("point_y", result.point_y, want.point_y);
        if (result.point_z !== want.point_z)
          report_mismatch("point_z", result.point_z, want.point_z);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(32'h000a_0000) - 32'h0005_0000;
    endcase
  endfunction

  function automatic query_t make_box_query(input logic corner_mode);
    query_t q;
    logic [31:0] a;
    logic [31:0] b;
    q = '0;
    q.box_min_x = -$signed($urandom_range(32'h0004_0000));
    q.box_min_y = -$signed($urandom_range(32'h0004_0000));
    q.box_min_z = -$signed($urandom_range(32'h0004_0000));
    q.box_max_x = $urandom_range(32'h0004_0000);
    q.box_max_y = $urandom_range(32'h0004_0000);
    q.box_max_z = $urandom_range(32'h0004_0000);
    a = $urandom_range(32'h0003_0000);
    b = $urandom_range(32'h0003_0000);
    q.end_x = $signed(a) - 32'sh0001_8000;
    q.end_y = $signed(b) - 32'sh0001_8000;
    q.end_z = $signed($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
    if (corner_mode) begin
      q.start_x = $signed($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
      q.start_y = $signed($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
      q.start_z = $signed($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
    end else begin
      q.start_x = $signed(rand_coord());
      q.start_y = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      q.start_z = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    end
    if ($urandom_range(7) == 0) q.end_z = q.start_z;
    if ($urandom_range(7) == 0) q.end_x = q.start_x;
    if ($urandom_range(7) == 0) q.end_y = q.start_y;
    return q;
  endfunction

  function automatic query_t make_noise_query();
    query_t q;
    q.start_x = rand_coord(); q.start_y = rand_coord(); q.start_z = rand_coord();
    q.end_x = rand_coord(); q.end_y = rand_coord(); q.end_z = rand_coord();
    q.box_min_x = rand_coord(); q.box_min_y = rand_coord(); q.box_min_z = rand_coord();
    q.box_max_x = rand_coord(); q.box_max_y = rand_coord(); q.box_max_z = rand_coord();
    return q;
  endfunction

  task automatic write_mode(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    mode_model = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_queries.size() > 0 || start || expected_hits.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic value, input int count, input logic idles);
    query_t q;
    write_mode(value);
    idle_enable = idles;
    q = '0;
    pending_queries.push_back(q);
    q.box_min_x = 32'sh8000_0000; q.box_min_y = 32'sh8000_0000;
    q.box_min_z = 32'sh8000_0000; q.box_max_x = 32'sh7fff_ffff;
    q.box_max_y = 32'sh7fff_ffff; q.box_max_z = 32'sh7fff_ffff;
    q.start_x = 32'sh8000_0000; q.start_y = 32'sh7fff_ffff; q.start_z = 32'sh8000_0000;
    q.end_x = 32'sh7fff_ffff; q.end_y = 32'sh8000_0000; q.end_z = 32'sh7fff_ffff;
    pending_queries.push_back(q);
    q.start_x = 32'sh7fff_ffff; q.end_x = 32'sh8000_0000;
    q.start_y = 32'sh0001_0000; q.end_y = 32'sh0001_0000;
    pending_queries.push_back(q);
    q = make_box_query(1'b1);
    q.box_min_x = 32'sh0001_0000; q.box_max_x = -32'sh0001_0000;
    pending_queries.push_back(q);
    q = make_box_query(1'b1);
    q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
    pending_queries.push_back(q);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) q = make_box_query(value);
      else q = make_noise_query();
      pending_queries.push_back(q);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    query = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    mode_model = 1'b0;
    mismatch_count = 0;
    sent_count = 0;
    checked_count = 0;
    hit_count = 0;
    idle_enable = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_phase(1'b0, 300, 1'b1);
    run_phase(1'b1, 300, 1'b0);
    run_phase(1'b0, 200, 1'b1);
    run_phase(1'b1, 280, 1'b1);
    $display("ran %0d queries in both entry modes, %0d results checked, %0d crossings",
             sent_count, checked_count, hit_count);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/sbfh_pkg.sv
hdl/sbfh_front.sv
hdl/sbfh_lane.sv
hdl/sbfh_back.sv
hdl/segment_box_face_hit.sv
test/segment_box_face_hit_tb.sv
